FILE: rtl/mlfr_pkg.sv
// Shared types and constants for the marker/length frame receiver.
// Holds the event codes, the result beat struct and the marker tables.
// No dependencies.
package mlfr_pkg;

  // Event codes carried on the result channel.
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_PAYLOAD   = 3'd1;
  localparam logic [2:0] EV_COMPLETE  = 3'd2;
  localparam logic [2:0] EV_BAD_LEN   = 3'd3;
  localparam logic [2:0] EV_BAD_END   = 3'd4;

  // Marker lengths and framing overhead.
  localparam logic [2:0]  START_LEN     = 3'd7;
  localparam logic [2:0]  END_LEN       = 3'd5;
  localparam logic [15:0] FRAME_OVERHEAD = 16'd14;
  localparam logic [7:0]  CHAR_LT       = 8'h3C;

  // Reset value of the payload limit register.
  localparam logic [12:0] MAX_LEN_RESET = 13'd4096;

  // One result beat.
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [12:0] frame_len;
    logic        last;
  } res_t;

  // Characters of the start marker "<START>".
  function automatic logic [7:0] start_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h3C;
      3'd1: c = 8'h53;
      3'd2: c = 8'h54;
      3'd3: c = 8'h41;
      3'd4: c = 8'h52;
      3'd5: c = 8'h54;
      3'd6: c = 8'h3E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of the end marker "<END>".
  function automatic logic [7:0] end_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h3C;
      3'd1: c = 8'h45;
      3'd2: c = 8'h4E;
      3'd3: c = 8'h44;
      3'd4: c = 8'h3E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/marker_length_frame_receiver.sv
// Top level of the marker/length frame receiver.
// Holds the payload limit register and joins the deframer and result register.
// Depends on mlfr_pkg, mlfr_core and mlfr_out_reg.
//
// Usage: received bytes enter as beats on the in_ channel (in_rx_byte). Frames
// look like "<START>", a big-endian 16-bit total length, the payload and
// "<END>"; the payload length is the total minus 14. Every input beat yields
// exactly one result beat on the out_ channel: an event code, the payload byte
// for payload events, the payload length for a complete frame, and last on
// any frame end (complete, bad length or bad end).
// out_valid rises in the cycle after input acceptance. Throughput is one
// byte per cycle unless stalled, set by the single result register after
// the deframer logic. When the receiver stalls (out_ready low with a result
// held), in_ready drops and the held beat stays unchanged until taken.
// The cfg_ channel writes the payload limit register; cfg_ready is always
// high and writes belong to idle periods. The effective limit is the smaller
// of that register and MAX_FRAME_PAYLOAD.
// Reset (rst_n low, synchronous) returns the receiver to hunting the start
// marker, empties the result register and sets the limit to 4096.
module marker_length_frame_receiver #(
  parameter int unsigned MAX_FRAME_PAYLOAD = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_data_byte,
  output logic [12:0] out_frame_len,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_max_payload_len
);
  import mlfr_pkg::*;

  logic [12:0] max_len_r;
  logic        step;
  logic        can_load;
  res_t        core_res;
  res_t        held_res;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_payload_len;
    end
  end

  // Input handshake.
  assign in_ready = can_load;
  assign step     = in_valid && can_load;

  mlfr_core #(
    .MAX_FRAME_PAYLOAD(MAX_FRAME_PAYLOAD)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_rx_byte),
    .max_len (max_len_r),
    .res     (core_res)
  );

  mlfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (core_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (held_res)
  );

  // Result fields.
  assign out_event_res = held_res.event_res;
  assign out_data_byte = held_res.data_byte;
  assign out_frame_len = held_res.frame_len;
  assign out_last      = held_res.last;

  // Every accepted byte produces a valid result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid)
    else $error("accepted byte produced no result");

  // Frame ends and last agree on the result channel.
  a_last_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_event_res == EV_COMPLETE ||
                                out_event_res == EV_BAD_LEN ||
                                out_event_res == EV_BAD_END)))
    else $error("last flag disagrees with event code");

  // Only payload beats carry a data byte.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_PAYLOAD) |-> out_data_byte == 8'd0)
    else $error("data byte set on a non-payload beat");

endmodule

FILE: rtl/mlfr_core.sv
// Deframing state machine: hunts the start marker, reads the length header,
// passes payload and checks the end marker, one byte per accepted beat.
// Depends on mlfr_pkg.
module mlfr_core #(
  parameter int unsigned MAX_FRAME_PAYLOAD = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [12:0]         max_len,
  output mlfr_pkg::res_t      res
);
  import mlfr_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_END     = 2'd3;

  localparam logic [15:0] FrameCap = 16'(MAX_FRAME_PAYLOAD);

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  start_cnt_r, start_cnt_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic        hdr_cnt_r, hdr_cnt_nxt;
  logic [12:0] pay_len_r, pay_len_nxt;
  logic [12:0] pay_cnt_r, pay_cnt_nxt;
  logic [2:0]  end_cnt_r, end_cnt_nxt;
  logic        end_bad_r, end_bad_nxt;

  logic [15:0] total;
  logic [15:0] body_len;
  logic [15:0] limit;
  logic [12:0] pay_cnt_inc;
  logic [2:0]  end_cnt_inc;
  logic        end_miss;

  // Header arithmetic and the effective payload limit.
  assign total       = {len_hi_r, rx_byte};
  assign body_len    = total - FRAME_OVERHEAD;
  assign limit       = (FrameCap < {3'b000, max_len}) ? FrameCap : {3'b000, max_len};
  assign pay_cnt_inc = pay_cnt_r + 13'd1;
  assign end_cnt_inc = end_cnt_r + 3'd1;
  assign end_miss    = (end_cnt_r >= END_LEN) || (rx_byte != end_char(end_cnt_r));

  // Next state and the result for the current byte.
  always_comb begin
    phase_nxt     = phase_r;
    start_cnt_nxt = start_cnt_r;
    len_hi_nxt    = len_hi_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    pay_len_nxt   = pay_len_r;
    pay_cnt_nxt   = pay_cnt_r;
    end_cnt_nxt   = end_cnt_r;
    end_bad_nxt   = end_bad_r;
    res           = '0;
    res.event_res = EV_NONE;

    case (phase_r)
      PH_IDLE: begin
        if (start_cnt_r < START_LEN && rx_byte == start_char(start_cnt_r)) begin
          if (start_cnt_r + 3'd1 == START_LEN) begin
            start_cnt_nxt = 3'd0;
            hdr_cnt_nxt   = 1'b0;
            phase_nxt     = PH_HEADER;
          end else begin
            start_cnt_nxt = start_cnt_r + 3'd1;
          end
        end else if (start_cnt_r != 3'd0) begin
          start_cnt_nxt = (rx_byte == CHAR_LT) ? 3'd1 : 3'd0;
        end
      end
      PH_HEADER: begin
        if (!hdr_cnt_r) begin
          len_hi_nxt  = rx_byte;
          hdr_cnt_nxt = 1'b1;
        end else begin
          hdr_cnt_nxt = 1'b0;
          if (total < FRAME_OVERHEAD || body_len > limit) begin
            // Length out of range: drop the frame and resume the hunt.
            res.event_res = EV_BAD_LEN;
            res.last      = 1'b1;
            phase_nxt     = PH_IDLE;
            start_cnt_nxt = 3'd0;
            end_cnt_nxt   = 3'd0;
            end_bad_nxt   = 1'b0;
          end else begin
            pay_len_nxt = body_len[12:0];
            pay_cnt_nxt = 13'd0;
            end_cnt_nxt = 3'd0;
            end_bad_nxt = 1'b0;
            phase_nxt   = (body_len[12:0] == 13'd0) ? PH_END : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res.event_res = EV_PAYLOAD;
        res.data_byte = rx_byte;
        pay_cnt_nxt   = pay_cnt_inc;
        if (pay_cnt_inc == pay_len_r) begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        end_bad_nxt = end_bad_r | end_miss;
        end_cnt_nxt = end_cnt_inc;
        if (end_cnt_inc >= END_LEN) begin
          if (!(end_bad_r | end_miss)) begin
            res.event_res = EV_COMPLETE;
            res.frame_len = pay_len_r;
          end else begin
            res.event_res = EV_BAD_END;
          end
          res.last      = 1'b1;
          phase_nxt     = PH_IDLE;
          start_cnt_nxt = 3'd0;
          hdr_cnt_nxt   = 1'b0;
          end_cnt_nxt   = 3'd0;
          end_bad_nxt   = 1'b0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // State registers, advanced on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      start_cnt_r <= 3'd0;
      len_hi_r    <= 8'd0;
      hdr_cnt_r   <= 1'b0;
      pay_len_r   <= 13'd0;
      pay_cnt_r   <= 13'd0;
      end_cnt_r   <= 3'd0;
      end_bad_r   <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      start_cnt_r <= start_cnt_nxt;
      len_hi_r    <= len_hi_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      pay_len_r   <= pay_len_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      end_cnt_r   <= end_cnt_nxt;
      end_bad_r   <= end_bad_nxt;
    end
  end

  // A partial start match never holds the full marker length.
  a_start_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    start_cnt_r != START_LEN)
    else $error("start match count reached marker length");

  // The end marker count stays below the marker length.
  a_end_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    end_cnt_r < END_LEN)
    else $error("end match count out of range");

  // While passing payload, fewer bytes have been seen than the frame holds.
  a_pay_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> pay_cnt_r < pay_len_r)
    else $error("payload count ran past payload length");

endmodule

FILE: rtl/mlfr_out_reg.sv
// Result register between the deframer and the result channel.
// Accepts a new result while the held one is being taken.
// Depends on mlfr_pkg.
module mlfr_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  mlfr_pkg::res_t res_in,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output mlfr_pkg::res_t res_out
);
  import mlfr_pkg::*;

  logic valid_r;
  res_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  // Valid flag: set by a load, cleared when the beat is taken with no refill.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  // A stalled result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |-> !load)
    else $error("result register loaded while stalled");

  // A stalled result stays valid and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> (valid_r && $stable(res_r)))
    else $error("stalled result changed");

  // A taken beat with no refill leaves the register empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_ready && !load) |=> !valid_r)
    else $error("taken result still marked valid");

endmodule
